@@ rtl/core/depq_pkg.sv @@
// ----------------------------------------------------------------------------
// depq_pkg: shared definitions of the double-ended priority queue
// Command and status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package depq_pkg;

	// Default configuration
	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed port field widths
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;
	localparam int OUT_W    = 32;

	// Heap select codes
	localparam logic HEAP_MIN = 1'b0;
	localparam logic HEAP_MAX = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT     = 2'd0,
		CMD_REMOVE_MIN = 2'd1,
		CMD_REMOVE_MAX = 2'd2,
		CMD_CLEAR      = 2'd3
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE     = 2'd0,
		STATUS_EMPTY    = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_e;

	// Which part of a command the purge loop belongs to
	typedef enum logic [1:0] {
		PH_PRE,
		PH_OP,
		PH_POST
	} phase_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_PURGE_RD,
		S_PURGE_TAG,
		S_PURGE_CHK,
		S_POP_TOP,
		S_POP_CLR,
		S_POP_LAST,
		S_SD_CHK,
		S_SD_L,
		S_SD_R,
		S_PUSH,
		S_SU_CHK,
		S_SU_CMP,
		S_DONE
	} state_e;

	// One result record as it leaves the sequencer
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                is_empty;
		logic [COUNT_W-1:0]  live_total;
		logic [OUT_W-1:0]    largest;
		logic [OUT_W-1:0]    smallest;
	} res_t;

endpackage

@@ rtl/core/depq_if.sv @@
// ----------------------------------------------------------------------------
// depq_if: command and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface depq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [31:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

interface depq_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               is_empty;
	logic [10:0]        live_total;
	logic signed [31:0] largest;
	logic signed [31:0] smallest;

	modport source (output valid, output status, output is_empty, output live_total,
		output largest, output smallest, input ready);
	modport sink (input valid, input status, input is_empty, input live_total,
		input largest, input smallest, output ready);
endinterface

@@ rtl/core/depq_ram.sv @@
// ----------------------------------------------------------------------------
// depq_ram: simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module depq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 42
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/depq_cmp.sv @@
// ----------------------------------------------------------------------------
// depq_cmp: shared heap order compare unit
// Tells whether value a goes ahead of value b in the selected heap.
// ----------------------------------------------------------------------------
module depq_cmp #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  is_max,
	input  logic [VALUE_BITS-1:0] a,
	input  logic [VALUE_BITS-1:0] b,
	output logic                  first
);

	logic a_lt_b;
	logic a_gt_b;

	// Signed two's complement compare, both directions.
	always_comb begin
		a_lt_b = $signed(a) < $signed(b);
		a_gt_b = $signed(a) > $signed(b);
		first  = is_max ? a_gt_b : a_lt_b;
	end

endmodule

@@ rtl/core/depq_seq.sv @@
// ----------------------------------------------------------------------------
// depq_seq: heap sequencer
// Runs insert, remove, clear and lazy purge over the two heap memories with
// one shared compare unit.
// ----------------------------------------------------------------------------
module depq_seq #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  depq_pkg::cmd_e     in_cmd,
	input  logic [31:0]        in_value,
	output logic               res_valid,
	input  logic               res_ready,
	output depq_pkg::res_t     res
);
	import depq_pkg::*;

	localparam int SW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int EW = VALUE_BITS + AW;

	state_e state_q, state_n;
	phase_e phase_q, phase_n;
	status_e status_q, status_n;
	cmd_e cmd_q, cmd_n;
	logic hsel_q, hsel_n;
	logic [SW-1:0] min_size_q, min_size_n, max_size_q, max_size_n;
	logic [SW-1:0] live_cnt_q, live_cnt_n, next_tag_q, next_tag_n;
	logic [SW-1:0] pos_q, pos_n;
	logic [EW-1:0] ins_q, ins_n, hole_q, hole_n, best_q, best_n, ent_q, ent_n;
	logic bkid_q, bkid_n;
	logic [VALUE_BITS-1:0] top_min_q, top_min_n, top_max_q, top_max_n;

	// Memory ports
	logic          heap_we;
	logic [AW-1:0] heap_waddr, heap_raddr;
	logic [EW-1:0] heap_wdata, min_rdata, max_rdata, rd;
	logic          live_we, live_wdata, live_rdata;
	logic [AW-1:0] live_waddr;

	// Compare unit ports
	logic [VALUE_BITS-1:0] cmp_a, cmp_b;
	logic                  cmp_first;

	logic [SW-1:0] cur_size;
	logic [SW:0]   kid;
	logic [63:0]   raw;
	logic [63:0]   ext_max, ext_min;
	logic [31:0]   cnt32;

	depq_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_min_heap (
		.clk(clk), .we(heap_we && hsel_q == HEAP_MIN), .waddr(heap_waddr),
		.wdata(heap_wdata), .raddr(heap_raddr), .rdata(min_rdata)
	);

	depq_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_max_heap (
		.clk(clk), .we(heap_we && hsel_q == HEAP_MAX), .waddr(heap_waddr),
		.wdata(heap_wdata), .raddr(heap_raddr), .rdata(max_rdata)
	);

	// Live bits, indexed by insertion tag; a tag is always set before it is read.
	depq_ram #(.DEPTH(CAPACITY), .WIDTH(1)) u_live (
		.clk(clk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
		.raddr(rd[AW-1:0]), .rdata(live_rdata)
	);

	depq_cmp #(.VALUE_BITS(VALUE_BITS)) u_cmp (
		.is_max(hsel_q), .a(cmp_a), .b(cmp_b), .first(cmp_first)
	);

	assign rd       = (hsel_q == HEAP_MAX) ? max_rdata : min_rdata;
	assign cur_size = (hsel_q == HEAP_MAX) ? max_size_q : min_size_q;
	assign kid      = {pos_q, 1'b0};
	assign raw      = {32'b0, in_value};

	// State and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_POST;
			status_q   <= STATUS_DONE;
			cmd_q      <= CMD_INSERT;
			hsel_q     <= HEAP_MIN;
			min_size_q <= '0;
			max_size_q <= '0;
			live_cnt_q <= '0;
			next_tag_q <= '0;
			pos_q      <= '0;
		end else begin
			state_q    <= state_n;
			phase_q    <= phase_n;
			status_q   <= status_n;
			cmd_q      <= cmd_n;
			hsel_q     <= hsel_n;
			min_size_q <= min_size_n;
			max_size_q <= max_size_n;
			live_cnt_q <= live_cnt_n;
			next_tag_q <= next_tag_n;
			pos_q      <= pos_n;
		end
	end

	always_ff @(posedge clk) begin
		ins_q     <= ins_n;
		hole_q    <= hole_n;
		best_q    <= best_n;
		bkid_q    <= bkid_n;
		ent_q     <= ent_n;
		top_min_q <= top_min_n;
		top_max_q <= top_max_n;
	end

	// Next state, memory control and compare operands.
	always_comb begin
		state_n    = state_q;
		phase_n    = phase_q;
		status_n   = status_q;
		cmd_n      = cmd_q;
		hsel_n     = hsel_q;
		min_size_n = min_size_q;
		max_size_n = max_size_q;
		live_cnt_n = live_cnt_q;
		next_tag_n = next_tag_q;
		pos_n      = pos_q;
		ins_n      = ins_q;
		hole_n     = hole_q;
		best_n     = best_q;
		bkid_n     = bkid_q;
		ent_n      = ent_q;
		top_min_n  = top_min_q;
		top_max_n  = top_max_q;
		heap_we    = 1'b0;
		heap_waddr = AW'(pos_q - 1'b1);
		heap_wdata = hole_q;
		heap_raddr = '0;
		live_we    = 1'b0;
		live_waddr = rd[AW-1:0];
		live_wdata = 1'b0;
		cmp_a      = rd[EW-1:AW];
		cmp_b      = hole_q[EW-1:AW];
		in_ready   = 1'b0;
		res_valid  = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_n   = in_cmd;
					ins_n   = {raw[VALUE_BITS-1:0], next_tag_q[AW-1:0]};
					state_n = S_DEC;
				end
			end

			// Decode the command and set up its first step.
			S_DEC: begin
				status_n = STATUS_DONE;
				hsel_n   = HEAP_MIN;
				phase_n  = PH_POST;
				state_n  = S_PURGE_RD;
				case (cmd_q)
					CMD_INSERT: begin
						if (next_tag_q == SW'(CAPACITY)) begin
							status_n = STATUS_OVERFLOW;
						end else begin
							live_we    = 1'b1;
							live_waddr = next_tag_q[AW-1:0];
							live_wdata = 1'b1;
							next_tag_n = next_tag_q + 1'b1;
							live_cnt_n = live_cnt_q + 1'b1;
							phase_n    = PH_OP;
							state_n    = S_PUSH;
						end
					end
					CMD_CLEAR: begin
						min_size_n = '0;
						max_size_n = '0;
						live_cnt_n = '0;
						next_tag_n = '0;
					end
					default: begin
						if (live_cnt_q == '0) begin
							min_size_n = '0;
							max_size_n = '0;
							status_n   = STATUS_EMPTY;
						end else begin
							phase_n = PH_PRE;
						end
					end
				endcase
			end

			// Purge loop: look at the top of the selected heap.
			S_PURGE_RD: begin
				if (cur_size == '0) begin
					if (hsel_q == HEAP_MIN) begin
						hsel_n = HEAP_MAX;
					end else if (phase_q == PH_PRE) begin
						phase_n = PH_OP;
						hsel_n  = (cmd_q == CMD_REMOVE_MAX) ? HEAP_MAX : HEAP_MIN;
						state_n = S_POP_TOP;
					end else begin
						state_n = S_DONE;
					end
				end else begin
					heap_raddr = '0;
					state_n    = S_PURGE_TAG;
				end
			end

			S_PURGE_TAG: begin
				ent_n   = rd;
				state_n = S_PURGE_CHK;
			end

			S_PURGE_CHK: begin
				if (live_rdata) begin
					if (hsel_q == HEAP_MIN) begin
						top_min_n = ent_q[EW-1:AW];
						hsel_n    = HEAP_MAX;
						state_n   = S_PURGE_RD;
					end else begin
						top_max_n = ent_q[EW-1:AW];
						if (phase_q == PH_PRE) begin
							phase_n = PH_OP;
							hsel_n  = (cmd_q == CMD_REMOVE_MAX) ? HEAP_MAX : HEAP_MIN;
							state_n = S_POP_TOP;
						end else begin
							state_n = S_DONE;
						end
					end
				end else begin
					// Stale top: its live bit is already clear.
					heap_raddr = AW'(cur_size - 1'b1);
					state_n    = S_POP_LAST;
				end
			end

			// Pop: retire the top, then move the last entry into the hole.
			S_POP_TOP: begin
				heap_raddr = '0;
				state_n    = S_POP_CLR;
			end

			S_POP_CLR: begin
				live_we    = 1'b1;
				live_waddr = rd[AW-1:0];
				live_wdata = 1'b0;
				heap_raddr = AW'(cur_size - 1'b1);
				state_n    = S_POP_LAST;
			end

			S_POP_LAST: begin
				hole_n = rd;
				pos_n  = SW'(1);
				if (hsel_q == HEAP_MAX) begin
					max_size_n = max_size_q - 1'b1;
				end else begin
					min_size_n = min_size_q - 1'b1;
				end
				state_n = S_SD_CHK;
			end

			// Sift down one level per pass.
			S_SD_CHK: begin
				if (kid <= {1'b0, cur_size}) begin
					heap_raddr = AW'(kid - 1'b1);
					state_n    = S_SD_L;
				end else begin
					heap_we = 1'b1;
					if (phase_q == PH_OP) begin
						live_cnt_n = live_cnt_q - 1'b1;
						phase_n    = PH_POST;
						hsel_n     = HEAP_MIN;
					end
					state_n = S_PURGE_RD;
				end
			end

			S_SD_L: begin
				cmp_a  = rd[EW-1:AW];
				cmp_b  = hole_q[EW-1:AW];
				best_n = cmp_first ? rd : hole_q;
				bkid_n = cmp_first;
				if (kid + 1'b1 <= {1'b0, cur_size}) begin
					heap_raddr = AW'(kid);
					state_n    = S_SD_R;
				end else if (cmp_first) begin
					heap_we    = 1'b1;
					heap_wdata = rd;
					pos_n      = SW'(kid);
					state_n    = S_SD_CHK;
				end else begin
					heap_we = 1'b1;
					if (phase_q == PH_OP) begin
						live_cnt_n = live_cnt_q - 1'b1;
						phase_n    = PH_POST;
						hsel_n     = HEAP_MIN;
					end
					state_n = S_PURGE_RD;
				end
			end

			S_SD_R: begin
				cmp_a = rd[EW-1:AW];
				cmp_b = best_q[EW-1:AW];
				if (cmp_first) begin
					heap_we    = 1'b1;
					heap_wdata = rd;
					pos_n      = SW'(kid + 1'b1);
					state_n    = S_SD_CHK;
				end else if (bkid_q) begin
					heap_we    = 1'b1;
					heap_wdata = best_q;
					pos_n      = SW'(kid);
					state_n    = S_SD_CHK;
				end else begin
					heap_we = 1'b1;
					if (phase_q == PH_OP) begin
						live_cnt_n = live_cnt_q - 1'b1;
						phase_n    = PH_POST;
						hsel_n     = HEAP_MIN;
					end
					state_n = S_PURGE_RD;
				end
			end

			// Push: open a hole at the end and sift it up.
			S_PUSH: begin
				if (hsel_q == HEAP_MAX) begin
					max_size_n = max_size_q + 1'b1;
				end else begin
					min_size_n = min_size_q + 1'b1;
				end
				pos_n   = cur_size + 1'b1;
				state_n = S_SU_CHK;
			end

			S_SU_CHK: begin
				heap_wdata = ins_q;
				if (pos_q > SW'(1)) begin
					heap_raddr = AW'((pos_q >> 1) - 1'b1);
					state_n    = S_SU_CMP;
				end else begin
					heap_we = 1'b1;
					if (hsel_q == HEAP_MIN) begin
						hsel_n  = HEAP_MAX;
						state_n = S_PUSH;
					end else begin
						phase_n = PH_POST;
						hsel_n  = HEAP_MIN;
						state_n = S_PURGE_RD;
					end
				end
			end

			S_SU_CMP: begin
				cmp_a   = ins_q[EW-1:AW];
				cmp_b   = rd[EW-1:AW];
				heap_we = 1'b1;
				if (cmp_first) begin
					heap_wdata = rd;
					pos_n      = pos_q >> 1;
					state_n    = S_SU_CHK;
				end else begin
					heap_wdata = ins_q;
					if (hsel_q == HEAP_MIN) begin
						hsel_n  = HEAP_MAX;
						state_n = S_PUSH;
					end else begin
						phase_n = PH_POST;
						hsel_n  = HEAP_MIN;
						state_n = S_PURGE_RD;
					end
				end
			end

			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_n = S_IDLE;
				end
			end

			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Result record.
	always_comb begin
		ext_max = {{(64-VALUE_BITS){top_max_q[VALUE_BITS-1]}}, top_max_q};
		ext_min = {{(64-VALUE_BITS){top_min_q[VALUE_BITS-1]}}, top_min_q};
		cnt32   = 32'(live_cnt_q);
		res.status     = status_q;
		res.is_empty   = (live_cnt_q == '0);
		res.live_total = cnt32[COUNT_W-1:0];
		if (live_cnt_q != '0 && min_size_q != '0 && max_size_q != '0) begin
			res.largest  = ext_max[OUT_W-1:0];
			res.smallest = ext_min[OUT_W-1:0];
		end else begin
			res.largest  = '0;
			res.smallest = '0;
		end
	end

endmodule

@@ rtl/core/double_ended_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit: double-ended priority queue
// Min-heap and max-heap over shared insertion tags with lazy deletion.
// ----------------------------------------------------------------------------
// One command is taken at a time and each gives one result. An insert runs
// two sift-ups, one per heap, and a removal one sift-down; every stale top
// purged adds a further pop and sift-down. A clear and an ignored removal
// walk no heap. The heap walks are paced by the single read port of each
// heap memory and the shared compare unit, visited once per heap level.
// A finished result waits in an output register while the next command is
// taken.
module double_ended_priority_queue_unit #(
	parameter int CAPACITY   = depq_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = depq_pkg::VALUE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	depq_req_if.sink   req,
	depq_rsp_if.source rsp
);
	import depq_pkg::*;

	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_q;
	logic out_valid_q;

	depq_seq #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.in_cmd(cmd_e'(req.cmd)), .in_value(req.value),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	// Output register: holds a result until its transfer.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_q.status;
	assign rsp.is_empty   = out_q.is_empty;
	assign rsp.live_total = out_q.live_total;
	assign rsp.largest    = out_q.largest;
	assign rsp.smallest   = out_q.smallest;

	// An empty queue reports zero extremes.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.is_empty |-> rsp.largest == '0 && rsp.smallest == '0)
		else $error("empty result with nonzero extremes");

	// The empty flag agrees with the live count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.is_empty == (rsp.live_total == '0))
		else $error("empty flag and live count disagree");

	// An ignored removal leaves the queue empty.
	a_ignored_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STATUS_EMPTY |-> rsp.is_empty)
		else $error("ignored removal on nonempty queue");

	// Commands are taken one at a time.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second command taken while busy");

endmodule
